FILE: hw/rtl/fibonacci_fast_doubling_macros.svh
// fibonacci_fast_doubling_macros.svh: assertion macros shared by the rtl
// depends on: nothing; expects clk_i and rst_ni in the including module
`ifndef FIBONACCI_FAST_DOUBLING_MACROS_SVH
`define FIBONACCI_FAST_DOUBLING_MACROS_SVH

// condition and consequence in the same cycle
`define FIBFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequence in the cycle after the condition
`define FIBFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/fibfd_pkg.sv
// fibfd_pkg.sv: widths, pair type and seed for the fast doubling pipeline
// depends on: nothing
`default_nettype none

package fibfd_pkg;

  // index and result field widths
  localparam int unsigned IndexW = 7;
  localparam int unsigned ValueW = 62;
  localparam int unsigned PrevW  = 61;

  // multiplier operands: every pair that is doubled is at most F(46)
  localparam int unsigned OpW   = 32;
  localparam int unsigned ProdW = 2 * OpW;

  // (F(n-1), F(n)) as it moves down the pipeline
  typedef struct packed {
    logic [PrevW-1:0]  prev;
    logic [ValueW-1:0] cur;
  } pair_t;

  // (F(-1), F(0)) = (1, 0): fixed point of doubling, so leading zero bits are harmless
  localparam pair_t PairSeed = '{prev: PrevW'(1), cur: ValueW'(0)};

endpackage

`default_nettype wire

FILE: hw/rtl/fibfd_step.sv
// fibfd_step.sv: one doubling level (operand prep, multiply, combine), three stages
// depends on: fibfd_pkg, fibonacci_fast_doubling_macros.svh
`default_nettype none
`include "fibonacci_fast_doubling_macros.svh"

module fibfd_step import fibfd_pkg::*; #(
  parameter int unsigned BitPos = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [IndexW-1:0] index_i,
  input  wire pair_t             pair_i,
  output logic                   valid_o,
  output logic [IndexW-1:0]      index_o,
  output pair_t                  pair_o
);

  logic              v1_q, v2_q, v3_q;
  logic [IndexW-1:0] idx1_q, idx2_q, idx3_q;
  logic [OpW-1:0]    a_q, b_q, t_q, t_d;
  logic [ProdW-1:0]  pp_q, cc_q, ct_q, pp_d, cc_d, ct_d;
  logic [ValueW-1:0] p2, c2;
  pair_t             pair_d, pair_q;

  // stage 1: operands F(m-1), F(m) and 2F(m-1) + F(m)
  assign t_d = {pair_i.prev[OpW-2:0], 1'b0} + pair_i.cur[OpW-1:0];

  // stage 2: three products
  assign pp_d = ProdW'(a_q) * ProdW'(a_q);
  assign cc_d = ProdW'(b_q) * ProdW'(b_q);
  assign ct_d = ProdW'(b_q) * ProdW'(t_q);

  // stage 3: F(2m-1), F(2m), then advance by one on a set bit
  always_comb begin
    p2 = pp_q[ValueW-1:0] + cc_q[ValueW-1:0];
    c2 = ct_q[ValueW-1:0];
    if (idx2_q[BitPos]) begin
      pair_d.prev = c2[PrevW-1:0];
      pair_d.cur  = p2 + c2;
    end else begin
      pair_d.prev = p2[PrevW-1:0];
      pair_d.cur  = c2;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    idx1_q <= index_i;
    a_q    <= pair_i.prev[OpW-1:0];
    b_q    <= pair_i.cur[OpW-1:0];
    t_q    <= t_d;
    idx2_q <= idx1_q;
    pp_q   <= pp_d;
    cc_q   <= cc_d;
    ct_q   <= ct_d;
    idx3_q <= idx2_q;
    pair_q <= pair_d;
  end

  assign valid_o = v3_q;
  assign index_o = idx3_q;
  assign pair_o  = pair_q;

  // checks
  `FIBFD_ASSERT_NEXT(a_step_v1, valid_i, v1_q, "step: word lost in stage 1")
  `FIBFD_ASSERT_NEXT(a_step_v3, v2_q, v3_q, "step: word lost in stage 3")
  `FIBFD_ASSERT_NOW(a_step_seed, v3_q && $past(valid_i && pair_i == PairSeed, 3),
    (pair_q == PairSeed) || (pair_q.prev == PrevW'(0) && pair_q.cur == ValueW'(1)),
    "step: seed pair did not double to F(0) or F(1)")

endmodule

`default_nettype wire

FILE: hw/rtl/fibonacci_fast_doubling.sv
// channel   | ports                                    | handshake
// ----------+------------------------------------------+---------------------------
// command   | index_i                                  | start, busy (busy stays low)
// result    | fib_value_o, fib_previous_o              | done_o, one cycle, no stall
//
// one index enters every cycle; the result leaves the last level together with done_o
// pipeline: one clamp stage, then three stages per bit of the index (seven levels)
// each level has three 32x32 multipliers of its own, so nothing is shared
// reset clears only the valid bits; the receiver cannot stall and nothing waits
//
// fibonacci_fast_doubling.sv: top level, index clamp and the chain of doubling levels
// depends on: fibfd_pkg, fibfd_step, fibonacci_fast_doubling_macros.svh
`default_nettype none
`include "fibonacci_fast_doubling_macros.svh"

module fibonacci_fast_doubling import fibfd_pkg::*; #(
  parameter int unsigned MAX_INDEX = 90
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [IndexW-1:0] index_i,
  output logic                   done_o,
  output logic [ValueW-1:0]      fib_value_o,
  output logic [PrevW-1:0]       fib_previous_o
);

  localparam logic [IndexW-1:0] MaxIdx = IndexW'(MAX_INDEX);

  logic              v0_q;
  logic [IndexW-1:0] idx0_q, idx0_d;

  logic              lvl_valid [IndexW+1];
  logic [IndexW-1:0] lvl_index [IndexW+1];
  pair_t             lvl_pair  [IndexW+1];

  // the pipeline never stalls
  assign busy = 1'b0;

  // clamp the index to the honored range
  assign idx0_d = (index_i > MaxIdx) ? MaxIdx : index_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    idx0_q <= idx0_d;
  end

  assign lvl_valid[0] = v0_q;
  assign lvl_index[0] = idx0_q;
  assign lvl_pair[0]  = PairSeed;

  // one doubling level per index bit, most significant first
  for (genvar k = 0; k < IndexW; k++) begin : g_lvl
    fibfd_step #(
      .BitPos (IndexW - 1 - k)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lvl_valid[k]),
      .index_i (lvl_index[k]),
      .pair_i  (lvl_pair[k]),
      .valid_o (lvl_valid[k+1]),
      .index_o (lvl_index[k+1]),
      .pair_o  (lvl_pair[k+1])
    );
  end

  assign done_o         = lvl_valid[IndexW];
  assign fib_value_o    = lvl_pair[IndexW].cur;
  assign fib_previous_o = lvl_pair[IndexW].prev;

  // checks
  `FIBFD_ASSERT_NOW(a_top_zero, done_o && fib_value_o == ValueW'(0),
    fib_previous_o == PrevW'(1), "top: zero value without previous of one")
  `FIBFD_ASSERT_NOW(a_top_range, done_o, lvl_index[IndexW] <= MaxIdx,
    "top: index past the bound reached the output")
  `FIBFD_ASSERT_NEXT(a_top_enter, start, v0_q, "top: accepted word did not enter")

endmodule

`default_nettype wire
